// ===== rtl/xss_pkg.sv =====
// xss_pkg: shared constants and types for the xoshiro128** generator with seed expansion
// no dependencies; used by the channel interfaces, the front and back modules and the top level
`default_nettype none

package xss_pkg;

  // word geometry
  localparam int WORD_W    = 32;
  localparam int NUM_WORDS = 4;
  localparam int ROUND_W   = 2;

  // seed expansion constants
  localparam logic [WORD_W-1:0] GOLDEN_INC = 32'h9e37_79b9;
  localparam logic [WORD_W-1:0] MIX_MUL_A  = 32'h21f0_aaad;
  localparam logic [WORD_W-1:0] MIX_MUL_B  = 32'h735a_2d97;

  // command codes
  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // one classified command as it travels from front to back
  typedef struct packed {
    logic              is_reseed;
    logic [WORD_W-1:0] seed;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/xss_in_if.sv =====
// xss_in_if: command channel (valid/ready with command and seed payload)
// depends on xss_pkg for the word width
`default_nettype none

interface xss_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [xss_pkg::WORD_W-1:0] seed;

  modport source (output valid, output command, output seed, input ready);
  modport sink   (input valid, input command, input seed, output ready);
endinterface

`default_nettype wire

// ===== rtl/xss_out_if.sv =====
// xss_out_if: result channel (valid/ready with the drawn value)
// depends on xss_pkg for the word width
`default_nettype none

interface xss_out_if;
  logic                      valid;
  logic                      ready;
  logic [xss_pkg::WORD_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/xoshiro128ss_with_seed_expansion.sv =====
// xoshiro128ss_with_seed_expansion: top level joining the command front end and the generator back end
// depends on xss_pkg, xss_in_if, xss_out_if, xss_front and xss_back
//
//   channel   role    beat payload            notes
//   in_chan   sink    command (1), seed (32)  command 0 draws, 1 reseeds
//   out_chan  source  value (32)              one beat per draw, none per reseed
//
// each draw is registered; back-to-back draws sustain one beat per cycle unless out_chan stalls
// a reseed is taken by the back end, which then runs four rounds of two passes
// through the shared multiplier and one word write
// after reset the back end runs the seed-zero expansion before it takes a command;
// the two-entry command queue keeps accepting meanwhile
// the output register lets a draw leave the back end while out_chan is stalled only if empty
`default_nettype none

module xoshiro128ss_with_seed_expansion (
  input  wire logic clk,
  input  wire logic rst_n,
  xss_in_if.sink    in_chan,
  xss_out_if.source out_chan
);

  xss_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  // command intake and queue
  xss_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // generator and seed expansion
  xss_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

// ===== rtl/xss_front.sv =====
// xss_front: accepts command beats, classifies them and holds them in a short queue
// depends on xss_pkg and xss_in_if
`default_nettype none

module xss_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  xss_in_if.sink            in_chan,
  output xss_pkg::item_t    q_item,
  output logic              q_valid,
  input  wire logic         q_pop
);

  xss_pkg::item_t              queue_r [xss_pkg::QDEPTH];
  logic [xss_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [xss_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [xss_pkg::QCNT_W-1:0]  count_r, count_nxt;
  logic                        push;
  logic                        pop;
  xss_pkg::item_t              item_in;

  // classify the incoming beat
  always_comb begin
    item_in.is_reseed = (in_chan.command == xss_pkg::CMD_RESEED);
    item_in.seed      = in_chan.seed;
  end

  assign in_chan.ready = (count_r != xss_pkg::QCNT_W'(xss_pkg::QDEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign q_valid       = (count_r != '0);
  assign pop           = q_pop && q_valid;
  assign q_item        = queue_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/xss_back.sv =====
// xss_back: generator state, draw datapath, seed expansion sequencer and output register
// depends on xss_pkg and xss_out_if
`default_nettype none

module xss_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire xss_pkg::item_t q_item,
  input  wire logic         q_valid,
  output logic              q_pop,
  xss_out_if.source         out_chan
);

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_MA  = 2'd1;
  localparam logic [1:0] ST_MB  = 2'd2;
  localparam logic [1:0] ST_WR  = 2'd3;

  localparam int W = xss_pkg::WORD_W;

  logic [1:0]                   state_r, state_nxt;
  logic [xss_pkg::ROUND_W-1:0]  round_r, round_nxt;
  logic [W-1:0]                 acc_r, acc_nxt;
  logic [W-1:0]                 prod_r;
  logic [W-1:0]                 words_r [xss_pkg::NUM_WORDS];
  logic                         out_valid_r, out_valid_nxt;
  logic [W-1:0]                 out_value_r;

  logic         pop_draw;
  logic         pop_reseed;
  logic [W-1:0] mul_a, mul_b;
  logic [W-1:0] mul_full;
  logic [W-1:0] mix_word;
  logic [W-1:0] s1x5, s1rot, draw_val;
  logic [W-1:0] t2, t3;

  // pop control: a draw needs room in the output register
  assign pop_draw   = q_valid && (state_r == ST_RUN) && !q_item.is_reseed &&
                      (!out_valid_r || out_chan.ready);
  assign pop_reseed = q_valid && (state_r == ST_RUN) && q_item.is_reseed;
  assign q_pop      = pop_draw || pop_reseed;

  // scrambled output: rotl(s1*5, 7)*9
  always_comb begin
    s1x5     = words_r[1] + {words_r[1][W-3:0], 2'b00};
    s1rot    = {s1x5[W-8:0], s1x5[W-1:W-7]};
    draw_val = s1rot + {s1rot[W-4:0], 3'b000};
  end

  // xor-shift state update terms
  assign t2 = words_r[2] ^ words_r[0];
  assign t3 = words_r[3] ^ words_r[1];

  // shared mixing multiplier, low word only
  always_comb begin
    if (state_r == ST_MA) begin
      mul_a = acc_r ^ (acc_r >> 16);
      mul_b = xss_pkg::MIX_MUL_A;
    end else begin
      mul_a = prod_r ^ (prod_r >> 15);
      mul_b = xss_pkg::MIX_MUL_B;
    end
    mul_full = mul_a * mul_b;
  end

  assign mix_word = prod_r ^ (prod_r >> 15);

  // expansion sequencer
  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    acc_nxt   = acc_r;
    case (state_r)
      ST_RUN: begin
        if (pop_reseed) begin
          state_nxt = ST_MA;
          round_nxt = '0;
          acc_nxt   = q_item.seed + xss_pkg::GOLDEN_INC;
        end
      end
      ST_MA: state_nxt = ST_MB;
      ST_MB: state_nxt = ST_WR;
      ST_WR: begin
        acc_nxt   = acc_r + xss_pkg::GOLDEN_INC;
        round_nxt = round_r + 1'b1;
        state_nxt = (round_r == xss_pkg::ROUND_W'(xss_pkg::NUM_WORDS - 1)) ? ST_RUN : ST_MA;
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // output register valid
  always_comb begin
    if (pop_draw) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers; reset runs the expansion of seed zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_MA;
      round_r     <= '0;
      acc_r       <= xss_pkg::GOLDEN_INC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // multiplier result register
  always_ff @(posedge clk) begin
    if (state_r == ST_MA || state_r == ST_MB) begin
      prod_r <= mul_full;
    end
  end

  // generator words: expansion write or draw advance
  always_ff @(posedge clk) begin
    if (state_r == ST_WR) begin
      words_r[round_r] <= mix_word;
    end else if (pop_draw) begin
      words_r[0] <= words_r[0] ^ t3;
      words_r[1] <= words_r[1] ^ t2;
      words_r[2] <= t2 ^ {words_r[1][W-10:0], 9'd0};
      words_r[3] <= {t3[W-12:0], t3[W-1:W-11]};
    end
  end

  // output value register
  always_ff @(posedge clk) begin
    if (pop_draw) begin
      out_value_r <= draw_val;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.value = out_value_r;

endmodule

`default_nettype wire

// ===== rtl/xss_checker.sv =====
// xss_checker: port-level assertions for the generator top level, bound in below
// depends on xss_pkg and on the top level's channel ports
`default_nettype none

module xss_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       in_command,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [xss_pkg::WORD_W-1:0] out_value
);

  logic [2:0] pending_r;
  logic       draw_beat;
  logic       out_beat;

  assign draw_beat = in_valid && in_ready && (in_command == xss_pkg::CMD_DRAW);
  assign out_beat  = out_valid && out_ready;

  // draws accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      case ({draw_beat, out_beat})
        2'b10:   pending_r <= pending_r + 1'b1;
        2'b01:   pending_r <= pending_r - 1'b1;
        default: pending_r <= pending_r;
      endcase
    end
  end

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value))
    else $error("result value changed while stalled");

  // no result without an outstanding draw (reseeds give none)
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("result beat without an outstanding draw");

  // queue plus output register bound the draws in flight
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'(xss_pkg::QDEPTH + 1))
    else $error("more draws in flight than storage allows");

endmodule

bind xoshiro128ss_with_seed_expansion xss_checker u_xss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_command (in_chan.command),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_value  (out_chan.value)
);

`default_nettype wire
